// File: rtl/core/rpfm_pkg.sv
// Package for the reflective pulse flow monitor.
// Holds widths, reset values, register indexes and the result item type.
// No dependencies.
package rpfm_pkg;

  localparam int unsigned SAMPLE_W = 10;
  localparam int unsigned PULSE_W  = 32;
  localparam int unsigned TICK_W   = 16;
  localparam int unsigned COUNT_W  = 2;
  localparam int unsigned CFG_W    = 16;
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [SAMPLE_W-1:0] THRESHOLD_RESET = SAMPLE_W'(440);
  localparam logic [TICK_W-1:0]   KEEPALIVE_RESET = TICK_W'(360);
  localparam logic [PULSE_W-1:0]  PULSE_ALL_ONES  = {PULSE_W{1'b1}};

  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_KEEPALIVE = 1'b1;

  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_TICK   = 1'b1;

  typedef struct packed {
    logic [COUNT_W-1:0] report_count;
    logic               report_status;
    logic [PULSE_W-1:0] report_pulses;
    logic               flow_status;
    logic [PULSE_W-1:0] pulse_count;
  } result_t;

endpackage

// File: rtl/core/reflective_pulse_flow_monitor_top.sv
// Top level of the reflective pulse flow monitor.
// Depends on rpfm_pkg for widths, reset values, register indexes and result_t.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one item: kind 0 is a sensor
//   sample, kind 1 is a report period tick. Every item gives exactly one
//   result item on the output channel (out_valid/out_ready) with the number
//   of reports asked for, their status and pulse count, and the flow status
//   and pulse counter after the item.
//   An item is evaluated in the cycle it is accepted; its result is
//   registered in the output register. One item per cycle is sustained
//   while the receiver keeps up, the rate being set by the single pass of
//   compare and increment logic between the state registers and the output
//   register. When the receiver stalls, one further item is taken into a
//   skid register and in_ready then drops until the output register drains.
//   Synchronous reset clears the flow state, the counters and both output
//   stages, and loads the threshold (440) and keepalive limit (360).
//   Configuration writes (cfg_we, cfg_index, cfg_data) take effect at once.
//   The user must make them only while idle; the block does not enforce it.
module reflective_pulse_flow_monitor_top (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                kind,
  input  logic [rpfm_pkg::SAMPLE_W-1:0]       sample,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [rpfm_pkg::COUNT_W-1:0]        report_count,
  output logic                                report_status,
  output logic [rpfm_pkg::PULSE_W-1:0]        report_pulses,
  output logic                                flow_status,
  output logic [rpfm_pkg::PULSE_W-1:0]        pulse_count,
  input  logic                                cfg_we,
  input  logic [rpfm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [rpfm_pkg::CFG_W-1:0]          cfg_data
);

  // Configuration registers.
  logic [rpfm_pkg::SAMPLE_W-1:0] threshold;
  logic [rpfm_pkg::TICK_W-1:0]   keepalive;

  // Monitor state.
  logic                         on_mark, on_mark_next;
  logic                         flowing, flowing_next;
  logic [rpfm_pkg::PULSE_W-1:0] pulses, pulses_next;
  logic [rpfm_pkg::PULSE_W-1:0] pulses_last, pulses_last_next;
  logic [rpfm_pkg::TICK_W-1:0]  ticks, ticks_next;

  // Output register and skid stage.
  rpfm_pkg::result_t out_reg, skid_reg, result;
  logic              skid_valid;

  logic                         accept;
  logic                         seen;
  logic                         wrap;
  logic                         first_flow;
  logic [rpfm_pkg::TICK_W-1:0]  ticks_inc;
  logic [rpfm_pkg::COUNT_W-1:0] count;
  logic                         rep_status;

  assign in_ready = !skid_valid;
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= rpfm_pkg::THRESHOLD_RESET;
      keepalive <= rpfm_pkg::KEEPALIVE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        rpfm_pkg::REG_THRESHOLD: threshold <= cfg_data[rpfm_pkg::SAMPLE_W-1:0];
        rpfm_pkg::REG_KEEPALIVE: keepalive <= cfg_data[rpfm_pkg::TICK_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    on_mark_next     = on_mark;
    flowing_next     = flowing;
    pulses_next      = pulses;
    pulses_last_next = pulses_last;
    ticks_next       = ticks;
    count            = '0;
    rep_status       = 1'b0;
    seen             = sample > threshold;
    wrap             = pulses == rpfm_pkg::PULSE_ALL_ONES;
    first_flow       = !flowing;
    ticks_inc        = ticks + rpfm_pkg::TICK_W'(1);

    if (kind == rpfm_pkg::KIND_SAMPLE) begin
      if (seen && !on_mark) begin
        // Rising edge of the mark: one pulse, and possibly two reports.
        on_mark_next = 1'b1;
        flowing_next = 1'b1;
        rep_status   = 1'b1;
        count = rpfm_pkg::COUNT_W'(first_flow) + rpfm_pkg::COUNT_W'(wrap);
        if (wrap) begin
          pulses_next      = '0;
          pulses_last_next = '0;
        end else begin
          pulses_next = pulses + rpfm_pkg::PULSE_W'(1);
        end
      end else if (!seen && on_mark) begin
        on_mark_next = 1'b0;
        flowing_next = 1'b1;
        rep_status   = 1'b1;
        count        = rpfm_pkg::COUNT_W'(first_flow);
      end
    end else begin
      ticks_next = ticks_inc;
      if (pulses > pulses_last) begin
        pulses_last_next = pulses;
      end else if (flowing) begin
        flowing_next = 1'b0;
        count        = rpfm_pkg::COUNT_W'(1);
      end else if (ticks_inc == keepalive) begin
        count = rpfm_pkg::COUNT_W'(1);
      end
    end

    // Any report restarts the keepalive count.
    if (count != '0) begin
      ticks_next = '0;
    end

    result.report_count  = count;
    result.report_status = (count != '0) ? rep_status : 1'b0;
    result.report_pulses = (count != '0) ? pulses : '0;
    result.flow_status   = flowing_next;
    result.pulse_count   = pulses_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      on_mark     <= 1'b0;
      flowing     <= 1'b0;
      pulses      <= '0;
      pulses_last <= '0;
      ticks       <= '0;
    end else if (accept) begin
      on_mark     <= on_mark_next;
      flowing     <= flowing_next;
      pulses      <= pulses_next;
      pulses_last <= pulses_last_next;
      ticks       <= ticks_next;
    end
  end

  // When both stages are full, the output register holds the older item and
  // the skid register the newer one.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      out_valid  <= skid_valid || accept;
      skid_valid <= 1'b0;
    end else if (accept) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || out_ready) begin
      out_reg <= skid_valid ? skid_reg : result;
    end else if (accept) begin
      skid_reg <= result;
    end
  end

  assign report_count  = out_reg.report_count;
  assign report_status = out_reg.report_status;
  assign report_pulses = out_reg.report_pulses;
  assign flow_status   = out_reg.flow_status;
  assign pulse_count   = out_reg.pulse_count;

endmodule
